[sv/lbgk_pkg.sv]
package lbgk_pkg;

    typedef logic signed [31:0] word_t;

    localparam int FRAC   = 28;
    localparam int NPOP   = 9;

    // velocity divider: quotient bits, bits per stage, stages
    localparam int QBITS   = 32;
    localparam int QSTEP   = 4;
    localparam int QSTAGES = QBITS / QSTEP;

    // divide-by-nine lanes: nine populations and four body-force terms
    localparam int NLANE  = 13;
    localparam int D9BITS = 40;
    localparam int D9HALF = D9BITS / 2;

    // pipeline stage positions
    localparam int ST_SUM   = 0;
    localparam int ST_PREP  = 1;
    localparam int ST_VEL   = ST_PREP + QSTAGES + 1;
    localparam int ST_SQ    = ST_VEL + 1;
    localparam int ST_POLY  = ST_SQ + 1;
    localparam int ST_PROD  = ST_POLY + 1;
    localparam int ST_D9A   = ST_PROD + 1;
    localparam int ST_D9B   = ST_D9A + 1;
    localparam int ST_FEQ   = ST_D9B + 1;
    localparam int ST_RELAX = ST_FEQ + 1;
    localparam int ST_OUT   = ST_RELAX + 1;
    localparam int NSTAGE   = ST_OUT + 1;

    // configuration register indexes
    localparam logic [1:0] REG_RELAX   = 2'd0;
    localparam logic [1:0] REG_FORCE_X = 2'd1;
    localparam logic [1:0] REG_FORCE_Y = 2'd2;

    localparam logic [29:0] RELAX_RESET   = 30'd268435456;
    localparam word_t       FORCE_X_RESET = 32'sd2684;
    localparam word_t       FORCE_Y_RESET = 32'sd0;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    // lattice directions and weight classes
    localparam int W_REST = 0;
    localparam int W_AXIS = 1;
    localparam int W_DIAG = 2;
    localparam int DIR_X [NPOP] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NPOP] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int WCLS  [NPOP] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                                    W_DIAG, W_DIAG, W_DIAG, W_DIAG};
    // body-force lane and sign for each population
    localparam int LANE_FX = 9;
    localparam int LANE_FY = 10;
    localparam int LANE_S1 = 11;
    localparam int LANE_S2 = 12;
    localparam int FLANE [NPOP] = '{0, LANE_FX, LANE_FY, LANE_FX, LANE_FY,
                                    LANE_S1, LANE_S2, LANE_S1, LANE_S2};
    localparam int FSIGN [NPOP] = '{0, 1, 1, -1, -1, 1, 1, -1, -1};

    typedef struct packed {
        logic [NPOP-1:0][31:0] f;
        logic [30:0]           rho;
        word_t                 ux;
        word_t                 uy;
    } car_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        word_t r;
        if (v > 64'sd2147483647)
            r = WORD_MAX;
        else if (v < -64'sd2147483648)
            r = WORD_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // four restoring steps: returns {quotient bits, remainder}
    function automatic logic [34:0] div_nib(input logic [30:0] r, input logic [30:0] d,
                                            input logic [3:0] bits);
        logic [31:0] t;
        logic [30:0] rr;
        logic [3:0]  q;
        rr = r;
        q  = '0;
        for (int j = 3; j >= 0; j--)
        begin
            t = {rr, bits[j]};
            if (t >= {1'b0, d})
            begin
                q[j] = 1'b1;
                rr   = 31'(t - {1'b0, d});
            end
            else
            begin
                rr = t[30:0];
            end
        end
        return {q, rr};
    endfunction

    // one hex digit of a divide by nine, t below 144: returns {digit, remainder}
    function automatic logic [7:0] digit9(input logic [7:0] t);
        logic [3:0] q;
        logic [7:0] rem;
        q = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (t >= 8'(9 * k))
                q = 4'(k);
        end
        rem = 8'(t - 8'(9 * q));
        return {q, rem[3:0]};
    endfunction

    // five digits of a divide by nine: returns {quotient, remainder}
    function automatic logic [23:0] div9_nibs(input logic [3:0] r, input logic [19:0] bits);
        logic [3:0]  rr;
        logic [19:0] q;
        logic [7:0]  d;
        rr = r;
        q  = '0;
        for (int j = 4; j >= 0; j--)
        begin
            d           = digit9({rr, bits[4*j +: 4]});
            q[4*j +: 4] = d[7:4];
            rr          = d[3:0];
        end
        return {q, rr};
    endfunction

endpackage

[sv/lattice_bgk_collision_d2q9_unit.sv]
// channel | handshake             | payload
// --------+-----------------------+------------------------------------------
// in      | in_valid / in_ready   | pop_rest .. pop_southeast
// out     | out_valid / out_ready | post_rest .. post_southeast, density,
//         |                       | velocity_x, velocity_y
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one cell per cycle sustained while the output is not stalled
// the velocity divider has 8 stages of 4 quotient bits each
// reset clears all stage valid bits and loads the register defaults
// each stage holds while the one after it is full and stalled, so bubbles
// close up and a waiting result stalls requests only once every stage is full
module lattice_bgk_collision_d2q9_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lbgk_pkg::word_t     pop_rest,
    input  lbgk_pkg::word_t     pop_east,
    input  lbgk_pkg::word_t     pop_north,
    input  lbgk_pkg::word_t     pop_west,
    input  lbgk_pkg::word_t     pop_south,
    input  lbgk_pkg::word_t     pop_northeast,
    input  lbgk_pkg::word_t     pop_northwest,
    input  lbgk_pkg::word_t     pop_southwest,
    input  lbgk_pkg::word_t     pop_southeast,
    output logic                out_valid,
    input  logic                out_ready,
    output lbgk_pkg::word_t     post_rest,
    output lbgk_pkg::word_t     post_east,
    output lbgk_pkg::word_t     post_north,
    output lbgk_pkg::word_t     post_west,
    output lbgk_pkg::word_t     post_south,
    output lbgk_pkg::word_t     post_northeast,
    output lbgk_pkg::word_t     post_northwest,
    output lbgk_pkg::word_t     post_southwest,
    output lbgk_pkg::word_t     post_southeast,
    output logic [30:0]         density,
    output lbgk_pkg::word_t     velocity_x,
    output lbgk_pkg::word_t     velocity_y,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int NP = lbgk_pkg::NPOP;
    localparam int NS = lbgk_pkg::NSTAGE;
    localparam int QS = lbgk_pkg::QSTAGES;
    localparam int NL = lbgk_pkg::NLANE;

    // configuration
    logic [29:0]      relax_reg;
    lbgk_pkg::word_t  force_x_reg;
    lbgk_pkg::word_t  force_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_reg   <= lbgk_pkg::RELAX_RESET;
            force_x_reg <= lbgk_pkg::FORCE_X_RESET;
            force_y_reg <= lbgk_pkg::FORCE_Y_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lbgk_pkg::REG_RELAX:   relax_reg   <= cfg_data[29:0];
                lbgk_pkg::REG_FORCE_X: force_x_reg <= cfg_data;
                lbgk_pkg::REG_FORCE_Y: force_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // per-item carry: populations, density, velocity
    lbgk_pkg::car_t car_reg  [NS];
    lbgk_pkg::car_t car_next [NS];

    logic [NP-1:0][31:0] pop_in;
    assign pop_in[0] = pop_rest;
    assign pop_in[1] = pop_east;
    assign pop_in[2] = pop_north;
    assign pop_in[3] = pop_west;
    assign pop_in[4] = pop_south;
    assign pop_in[5] = pop_northeast;
    assign pop_in[6] = pop_northwest;
    assign pop_in[7] = pop_southwest;
    assign pop_in[8] = pop_southeast;

    // stage 0: density and momenta
    logic signed [35:0] sum_all, mx_sum, my_sum;
    logic [30:0]        rho_clamp;
    logic signed [35:0] mx_reg, my_reg;

    always_comb
    begin
        sum_all = '0;
        mx_sum  = '0;
        my_sum  = '0;
        for (int i = 0; i < NP; i++)
        begin
            sum_all = sum_all + 36'($signed(pop_in[i]));
            if (lbgk_pkg::DIR_X[i] == 1)
                mx_sum = mx_sum + 36'($signed(pop_in[i]));
            else if (lbgk_pkg::DIR_X[i] == -1)
                mx_sum = mx_sum - 36'($signed(pop_in[i]));
            if (lbgk_pkg::DIR_Y[i] == 1)
                my_sum = my_sum + 36'($signed(pop_in[i]));
            else if (lbgk_pkg::DIR_Y[i] == -1)
                my_sum = my_sum - 36'($signed(pop_in[i]));
        end
        if (sum_all < 36'sd1)
            rho_clamp = 31'd1;
        else if (sum_all > 36'sd2147483647)
            rho_clamp = 31'h7fffffff;
        else
            rho_clamp = sum_all[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_SUM])
        begin
            mx_reg <= mx_sum;
            my_reg <= my_sum;
        end
    end

    // stage 1: divider setup, magnitude and overflow of momentum / density
    logic [34:0] mag [2];
    logic [30:0] dr_reg  [QS+1][2];
    logic [31:0] dq_reg  [QS+1][2];
    logic [1:0]  dsg_reg [QS+1];
    logic [1:0]  dov_reg [QS+1];
    logic [3:0]  lo_reg  [2];
    logic [34:0] step    [QS+1][2];

    always_comb
    begin
        mag[0] = mx_reg[35] ? 35'(-mx_reg) : 35'(mx_reg);
        mag[1] = my_reg[35] ? 35'(-my_reg) : 35'(my_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_PREP])
        begin
            for (int a = 0; a < 2; a++)
            begin
                // quotient of 2^32 or more saturates whatever its low bits
                dov_reg[0][a] <= mag[a] >= {car_reg[lbgk_pkg::ST_SUM].rho, 4'b0};
                dr_reg[0][a]  <= (mag[a] >= {car_reg[lbgk_pkg::ST_SUM].rho, 4'b0}) ?
                                 31'd0 : mag[a][34:4];
                dq_reg[0][a]  <= '0;
                lo_reg[a]     <= mag[a][3:0];
            end
            dsg_reg[0] <= {my_reg[35], mx_reg[35]};
        end
    end

    // divider stages
    always_comb
    begin
        step[0][0] = '0;
        step[0][1] = '0;
        for (int k = 1; k <= QS; k++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                step[k][a] = lbgk_pkg::div_nib(dr_reg[k-1][a],
                                               car_reg[lbgk_pkg::ST_PREP+k-1].rho,
                                               (k == 1) ? lo_reg[a] : 4'b0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= QS; k++)
        begin
            if (en[lbgk_pkg::ST_PREP+k])
            begin
                for (int a = 0; a < 2; a++)
                begin
                    dr_reg[k][a] <= step[k][a][30:0];
                    dq_reg[k][a] <= {dq_reg[k-1][a][lbgk_pkg::QBITS-lbgk_pkg::QSTEP-1:0],
                                     step[k][a][34:31]};
                end
                dsg_reg[k] <= dsg_reg[k-1];
                dov_reg[k] <= dov_reg[k-1];
            end
        end
    end

    // velocity stage: signed saturation and projections on the directions
    lbgk_pkg::word_t    vel [2];
    lbgk_pkg::word_t    cu  [NP];
    lbgk_pkg::word_t    cu_reg [NP];
    logic signed [63:0] proj;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (dov_reg[QS][a] || dq_reg[QS][a][31])
                vel[a] = dsg_reg[QS][a] ? lbgk_pkg::WORD_MIN : lbgk_pkg::WORD_MAX;
            else
                vel[a] = dsg_reg[QS][a] ? 32'(32'd0 - dq_reg[QS][a]) : dq_reg[QS][a];
        end
        proj = '0;
        for (int i = 0; i < NP; i++)
        begin
            proj = '0;
            if (lbgk_pkg::DIR_X[i] == 1)
                proj = proj + 64'(vel[0]);
            else if (lbgk_pkg::DIR_X[i] == -1)
                proj = proj - 64'(vel[0]);
            if (lbgk_pkg::DIR_Y[i] == 1)
                proj = proj + 64'(vel[1]);
            else if (lbgk_pkg::DIR_Y[i] == -1)
                proj = proj - 64'(vel[1]);
            cu[i] = lbgk_pkg::sat32(proj);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_VEL])
        begin
            for (int i = 0; i < NP; i++)
                cu_reg[i] <= cu[i];
        end
    end

    // squares
    logic signed [63:0] sqf_reg [NP];
    logic signed [63:0] uxx_reg, uyy_reg;
    lbgk_pkg::word_t    cu2_reg [NP];

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_SQ])
        begin
            for (int i = 0; i < NP; i++)
            begin
                sqf_reg[i] <= cu_reg[i] * cu_reg[i];
                cu2_reg[i] <= cu_reg[i];
            end
            uxx_reg <= car_reg[lbgk_pkg::ST_VEL].ux * car_reg[lbgk_pkg::ST_VEL].ux;
            uyy_reg <= car_reg[lbgk_pkg::ST_VEL].uy * car_reg[lbgk_pkg::ST_VEL].uy;
        end
    end

    // equilibrium polynomial
    logic [63:0]        usum;
    logic [35:0]        usq;
    logic signed [63:0] usq64;
    logic signed [63:0] sq64 [NP];
    logic signed [63:0] poly [NP];
    lbgk_pkg::word_t    p_reg [NP];

    always_comb
    begin
        usum  = uxx_reg + uyy_reg;
        usq   = usum[63:lbgk_pkg::FRAC];
        usq64 = $signed({28'b0, usq});
        for (int i = 0; i < NP; i++)
        begin
            sq64[i] = $signed({29'b0, sqf_reg[i][62:lbgk_pkg::FRAC]});
            poly[i] = 64'sd268435456 + 3 * 64'(cu2_reg[i])
                    + ((9 * sq64[i]) >>> 1) - ((3 * usq64) >>> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_POLY])
        begin
            for (int i = 0; i < NP; i++)
                p_reg[i] <= lbgk_pkg::sat32(poly[i]);
        end
    end

    // density times polynomial
    logic signed [31:0] rho_s;
    logic signed [63:0] prod_reg [NP];

    assign rho_s = $signed({1'b0, car_reg[lbgk_pkg::ST_POLY].rho});

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_PROD])
        begin
            for (int i = 0; i < NP; i++)
                prod_reg[i] <= rho_s * p_reg[i];
        end
    end

    // weights: divide by nine over two stages, populations and body force
    logic signed [63:0] rp   [NP];
    logic [39:0]        rmag [NP];
    logic [39:0]        dvd  [NL];
    logic [NL-1:0]      lsgn;
    logic signed [63:0] fx64, fy64, fs1, fs2;
    logic [63:0]        fxa, fya, fs1a, fs2a;
    logic [23:0]        d9a  [NL];
    logic [23:0]        d9b  [NL];
    logic [19:0]        qhi_reg [NL];
    logic [3:0]         rem_reg [NL];
    logic [19:0]        low_reg [NL];
    logic [NL-1:0]      sa_reg, sb_reg;
    logic [39:0]        q9_reg  [NL];

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            rp[i]   = prod_reg[i] >>> lbgk_pkg::FRAC;
            rmag[i] = 40'(rp[i][63] ? -rp[i] : rp[i]);
            lsgn[i] = rp[i][63];
            case (lbgk_pkg::WCLS[i])
                lbgk_pkg::W_REST: dvd[i] = {rmag[i][37:0], 2'b0};
                lbgk_pkg::W_AXIS: dvd[i] = rmag[i];
                default:          dvd[i] = {2'b0, rmag[i][39:2]};
            endcase
        end
        fx64 = 64'(force_x_reg);
        fy64 = 64'(force_y_reg);
        fs1  = fx64 + fy64;
        fs2  = fy64 - fx64;
        fxa  = 3 * (fx64[63] ? -fx64 : fx64);
        fya  = 3 * (fy64[63] ? -fy64 : fy64);
        fs1a = 3 * (fs1[63] ? -fs1 : fs1);
        fs2a = 3 * (fs2[63] ? -fs2 : fs2);
        dvd[lbgk_pkg::LANE_FX]  = fxa[39:0];
        dvd[lbgk_pkg::LANE_FY]  = fya[39:0];
        dvd[lbgk_pkg::LANE_S1]  = fs1a[41:2];
        dvd[lbgk_pkg::LANE_S2]  = fs2a[41:2];
        lsgn[lbgk_pkg::LANE_FX] = fx64[63];
        lsgn[lbgk_pkg::LANE_FY] = fy64[63];
        lsgn[lbgk_pkg::LANE_S1] = fs1[63];
        lsgn[lbgk_pkg::LANE_S2] = fs2[63];
        for (int l = 0; l < NL; l++)
        begin
            d9a[l] = lbgk_pkg::div9_nibs(4'd0, dvd[l][39:lbgk_pkg::D9HALF]);
            d9b[l] = lbgk_pkg::div9_nibs(rem_reg[l], low_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_D9A])
        begin
            for (int l = 0; l < NL; l++)
            begin
                qhi_reg[l] <= d9a[l][23:4];
                rem_reg[l] <= d9a[l][3:0];
                low_reg[l] <= dvd[l][lbgk_pkg::D9HALF-1:0];
            end
            sa_reg <= lsgn;
        end
        if (en[lbgk_pkg::ST_D9B])
        begin
            for (int l = 0; l < NL; l++)
                q9_reg[l] <= {qhi_reg[l], d9b[l][23:4]};
            sb_reg <= sa_reg;
        end
    end

    // equilibrium and deviation from it
    logic signed [63:0] qs   [NL];
    logic signed [63:0] fterm;
    lbgk_pkg::word_t    feq  [NP];
    logic signed [32:0] diff_reg [NP];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            qs[l] = sb_reg[l] ? -$signed({24'b0, q9_reg[l]}) : $signed({24'b0, q9_reg[l]});
        fterm = '0;
        for (int i = 0; i < NP; i++)
        begin
            if (lbgk_pkg::FSIGN[i] == 1)
                fterm = qs[lbgk_pkg::FLANE[i]];
            else if (lbgk_pkg::FSIGN[i] == -1)
                fterm = -qs[lbgk_pkg::FLANE[i]];
            else
                fterm = '0;
            feq[i] = lbgk_pkg::sat32(qs[i] + fterm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_FEQ])
        begin
            for (int i = 0; i < NP; i++)
                diff_reg[i] <= 33'($signed(car_reg[lbgk_pkg::ST_D9B].f[i])) - 33'(feq[i]);
        end
    end

    // relaxation
    logic signed [31:0] omega_s;
    logic signed [63:0] rel_reg  [NP];
    lbgk_pkg::word_t    post_reg [NP];

    assign omega_s = $signed({2'b0, relax_reg});

    always_ff @(posedge clk)
    begin
        if (en[lbgk_pkg::ST_RELAX])
        begin
            for (int i = 0; i < NP; i++)
                rel_reg[i] <= omega_s * diff_reg[i];
        end
        if (en[lbgk_pkg::ST_OUT])
        begin
            for (int i = 0; i < NP; i++)
                post_reg[i] <= lbgk_pkg::sat32(64'($signed(car_reg[lbgk_pkg::ST_RELAX].f[i]))
                                               - (rel_reg[i] >>> lbgk_pkg::FRAC));
        end
    end

    // carry chain
    always_comb
    begin
        car_next[0].f   = pop_in;
        car_next[0].rho = rho_clamp;
        car_next[0].ux  = '0;
        car_next[0].uy  = '0;
        for (int k = 1; k < NS; k++)
        begin
            car_next[k] = car_reg[k-1];
            if (k == lbgk_pkg::ST_VEL)
            begin
                car_next[k].ux = vel[0];
                car_next[k].uy = vel[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
                car_reg[k] <= car_next[k];
        end
    end

    assign post_rest      = post_reg[0];
    assign post_east      = post_reg[1];
    assign post_north     = post_reg[2];
    assign post_west      = post_reg[3];
    assign post_south     = post_reg[4];
    assign post_northeast = post_reg[5];
    assign post_northwest = post_reg[6];
    assign post_southwest = post_reg[7];
    assign post_southeast = post_reg[8];
    assign density        = car_reg[lbgk_pkg::ST_OUT].rho;
    assign velocity_x     = car_reg[lbgk_pkg::ST_OUT].ux;
    assign velocity_y     = car_reg[lbgk_pkg::ST_OUT].uy;

    // an empty output register lets the whole pipeline move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    // density is floored, so a result never carries zero
    a_density_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> density != 31'd0)
        else $error("zero density on output");

    // divider remainder stays below the divisor
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[lbgk_pkg::ST_VEL-1] |->
            (dr_reg[QS][0] < car_reg[lbgk_pkg::ST_VEL-1].rho) &&
            (dr_reg[QS][1] < car_reg[lbgk_pkg::ST_VEL-1].rho))
        else $error("velocity divider remainder out of range");

endmodule
